### rtl/core/calendar_clock_with_adjust_core_macros.svh
// Assertion macros used by the calendar clock checker
`ifndef CALENDAR_CLOCK_WITH_ADJUST_CORE_MACROS_SVH
`define CALENDAR_CLOCK_WITH_ADJUST_CORE_MACROS_SVH

// same-cycle implication, muted during reset
`define CWA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted during reset
`define CWA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must hold in the cycle after reset
`define CWA_ASSERT_RST(label, cond, msg) \
   label: assert property (@(posedge clock) reset |=> (cond)) \
      else $error(msg);

`endif

### rtl/core/cwa_pkg.sv
// Constants, codes and calendar tables for the calendar clock
`timescale 1ns / 1ps
`default_nettype none

package cwa_pkg;

   localparam logic [2:0] KIND_TICK     = 3'd0;
   localparam logic [2:0] KIND_ADD_MIN  = 3'd1;
   localparam logic [2:0] KIND_SUB_MIN  = 3'd2;
   localparam logic [2:0] KIND_DAY_FWD  = 3'd3;
   localparam logic [2:0] KIND_DAY_BACK = 3'd4;
   localparam logic [2:0] KIND_LOAD     = 3'd5;

   // reciprocals: 1000 and 7 rounded down (quotient exact or one short), 100 rounded up
   localparam logic [13:0] RECIP_1000 = 14'd1048;  // >> 20
   localparam logic [13:0] RECIP_100  = 14'd5243;  // >> 19, exact below 16384
   localparam logic [13:0] RECIP_7    = 14'd9362;  // >> 16

   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] o;
      case (m)
         4'd2:    o = 9'd31;
         4'd3:    o = 9'd59;
         4'd4:    o = 9'd90;
         4'd5:    o = 9'd120;
         4'd6:    o = 9'd151;
         4'd7:    o = 9'd181;
         4'd8:    o = 9'd212;
         4'd9:    o = 9'd243;
         4'd10:   o = 9'd273;
         4'd11:   o = 9'd304;
         4'd12:   o = 9'd334;
         default: o = 9'd0;
      endcase
      return o;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] l;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
         default:                                    l = 5'd28 + {4'd0, leap};
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

### rtl/core/calendar_clock_with_adjust_core.sv
// Calendar clock core: sequencer around one shared constant multiplier
//
//   channel | direction | handshake             | word
//   req_    | in        | req_valid / req_stall | kind, elapsed ms, minutes, load date
//   rsp_    | out       | rsp_valid / rsp_stall | date, time, weekday, rolled flags
//
// A tick does more work when it rolls the day, and more again if the weekday
// has to be recomputed (a date before START_YEAR skips that arithmetic). A
// minute adjust runs the subtract-60 loop, then a day step per day carried
// (two at most), the weekday and the hand-over. Each multiply goes through the
// one registered multiplier. req_stall is high from acceptance until the result
// is in the output register; a waiting result does not block the next word.
// Reset is synchronous and puts the clock at START_YEAR-01-01 00:00:00.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_with_adjust_core
   import cwa_pkg::*;
#(
   parameter int START_YEAR    = 1900,
   parameter int START_WEEKDAY = 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [15:0] req_elapsed_ms,
   input  wire logic [10:0] req_minutes,
   input  wire logic [13:0] req_load_year,
   input  wire logic [3:0]  req_load_month,
   input  wire logic [4:0]  req_load_day,
   input  wire logic [4:0]  req_load_hour,
   input  wire logic [5:0]  req_load_minute,
   input  wire logic [5:0]  req_load_second,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [13:0]      rsp_year,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second,
   output logic [2:0]       rsp_weekday,
   output logic             rsp_minute_rolled,
   output logic             rsp_hour_rolled,
   output logic             rsp_day_rolled,
   output logic             rsp_month_rolled,
   output logic             rsp_year_rolled
);

   localparam logic [13:0] START_Y = 14'(START_YEAR);
   localparam logic [15:0] LEAPS_BEFORE =
      16'((START_YEAR - 1) / 4 - (START_YEAR - 1) / 100 + (START_YEAR - 1) / 400);
   localparam logic [15:0] WD_BASE = 16'(6 + START_WEEKDAY);
   localparam logic [2:0]  START_WD = 3'(START_WEEKDAY);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_MS_MUL    = 17'h00002,
      ST_MS_FIX    = 17'h00004,
      ST_MS_REM    = 17'h00008,
      ST_SEC       = 17'h00010,
      ST_MIN_DIV   = 17'h00020,
      ST_MIN_APPLY = 17'h00040,
      ST_LEAP_MUL  = 17'h00080,
      ST_LEAP_FIX  = 17'h00100,
      ST_STEP      = 17'h00200,
      ST_WD_MUL1   = 17'h00400,
      ST_WD_MUL2   = 17'h00800,
      ST_WD_LEAP   = 17'h01000,
      ST_WD_SUM    = 17'h02000,
      ST_WD_MUL7   = 17'h04000,
      ST_WD_MOD    = 17'h08000,
      ST_DONE      = 17'h10000
   } state_type;

   typedef struct packed {
      logic minute;
      logic hour;
      logic day;
      logic month;
      logic year;
   } rolled_type;

   state_type  state_ff, state_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [2:0]  wd_ff, wd_in;
   logic [9:0]  rem_ff, rem_in;
   rolled_type  rolled_ff, rolled_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // per-word working registers
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] ms_ff, ms_in;
   logic [10:0] mins_ff, mins_in;
   logic [5:0]  h_ff, h_in;
   logic [1:0]  days_ff, days_in;
   logic        fwd_ff, fwd_in;
   logic        leap_ff, leap_in;
   logic [6:0]  secs_ff, secs_in;
   logic [9:0]  part_ff, part_in;
   logic [7:0]  q1_ff, q1_in;
   logic [14:0] n_ff, n_in;

   // shared multiplier
   logic [15:0] mul_a;
   logic [13:0] mul_b;
   logic [29:0] prod_ff, prod_in;

   // leap year of year_ff from prod_ff = year_ff * RECIP_100
   logic [7:0]  cent_q;
   logic [13:0] cent_r;
   logic        leap_calc;

   logic        is_tick;
   logic [13:0] year_m1;

   assign is_tick = (kind_ff == KIND_TICK);
   assign year_m1 = year_ff - 14'd1;
   assign cent_q  = prod_ff[26:19];
   assign cent_r  = year_ff - 14'({6'd0, cent_q} * 14'd100);
   assign leap_calc = ((year_ff[1:0] == 2'd0) && (cent_r != 14'd0)) ||
                      ((cent_r == 14'd0) && (cent_q[1:0] == 2'd0));

   always_comb begin
      mul_a = 16'd0;
      mul_b = 14'd0;
      case (state_ff)
         ST_MS_MUL: begin
            mul_a = ms_ff;
            mul_b = RECIP_1000;
         end
         ST_LEAP_MUL, ST_WD_MUL2: begin
            mul_a = {2'd0, year_ff};
            mul_b = RECIP_100;
         end
         ST_WD_MUL1: begin
            mul_a = {2'd0, year_m1};
            mul_b = RECIP_100;
         end
         ST_WD_MUL7: begin
            mul_a = {1'b0, n_ff};
            mul_b = RECIP_7;
         end
         default: begin
            mul_a = 16'd0;
            mul_b = 14'd0;
         end
      endcase
      prod_in = {14'd0, mul_a} * {16'd0, mul_b};
   end

   always_comb begin
      logic [6:0]  q;
      logic [16:0] qk;
      logic [16:0] r;
      logic [10:0] rs;
      logic [7:0]  s;
      logic [6:0]  mt;
      logic [5:0]  ht;
      logic [5:0]  m;
      logic [4:0]  hh;
      logic [1:0]  dd;
      logic [4:0]  mlen;
      logic [5:0]  d;
      logic [4:0]  mn;
      logic [15:0] sum;
      logic [12:0] q7;
      logic [15:0] r7;
      logic [3:0]  r7n;

      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      wd_in        = wd_ff;
      rem_in       = rem_ff;
      rolled_in    = rolled_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      ms_in        = ms_ff;
      mins_in      = mins_ff;
      h_in         = h_ff;
      days_in      = days_ff;
      fwd_in       = fwd_ff;
      leap_in      = leap_ff;
      secs_in      = secs_ff;
      part_in      = part_ff;
      q1_in        = q1_ff;
      n_in         = n_ff;

      q = 7'd0; qk = 17'd0; r = 17'd0; rs = 11'd0; s = 8'd0; mt = 7'd0;
      ht = 6'd0; m = 6'd0; hh = 5'd0; dd = 2'd0; mlen = 5'd0; d = 6'd0;
      mn = 5'd0; sum = 16'd0; q7 = 13'd0; r7 = 16'd0; r7n = 4'd0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               ms_in     = req_elapsed_ms;
               mins_in   = req_minutes;
               h_in      = 6'd0;
               rolled_in = '0;
               case (req_kind)
                  KIND_TICK:    state_in = ST_MS_MUL;
                  KIND_ADD_MIN: state_in = ST_MIN_DIV;
                  KIND_SUB_MIN: state_in = ST_MIN_DIV;
                  KIND_DAY_FWD: begin
                     days_in  = 2'd1;
                     fwd_in   = 1'b1;
                     state_in = ST_LEAP_MUL;
                  end
                  KIND_DAY_BACK: begin
                     days_in  = 2'd1;
                     fwd_in   = 1'b0;
                     state_in = ST_LEAP_MUL;
                  end
                  KIND_LOAD: begin
                     year_in   = req_load_year;
                     month_in  = req_load_month;
                     day_in    = req_load_day;
                     hour_in   = req_load_hour;
                     minute_in = req_load_minute;
                     second_in = req_load_second;
                     rem_in    = 10'd0;
                     state_in  = ST_WD_MUL1;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_MS_MUL: state_in = ST_MS_FIX;

         ST_MS_FIX: begin
            q  = prod_ff[26:20];
            qk = {q, 10'd0} - {6'd0, q, 4'd0} - {7'd0, q, 3'd0};
            r  = {1'b0, ms_ff} - qk;
            if (r[10:0] >= 11'd1000) begin
               secs_in = q + 7'd1;
               part_in = 10'(r[10:0] - 11'd1000);
            end else begin
               secs_in = q;
               part_in = r[9:0];
            end
            state_in = ST_MS_REM;
         end

         ST_MS_REM: begin
            rs = {1'b0, rem_ff} + {1'b0, part_ff};
            if (rs >= 11'd1000) begin
               rem_in  = 10'(rs - 11'd1000);
               secs_in = secs_ff + 7'd1;
            end else begin
               rem_in = rs[9:0];
            end
            state_in = ST_SEC;
         end

         ST_SEC: begin
            state_in = ST_DONE;
            s = {2'd0, second_ff} + {1'b0, secs_ff};
            if (s > 8'd59) begin
               rolled_in.minute = 1'b1;
               if (s >= 8'd120) begin
                  second_in = 6'(s - 8'd120);
                  mt = {1'b0, minute_ff} + 7'd2;
               end else begin
                  second_in = 6'(s - 8'd60);
                  mt = {1'b0, minute_ff} + 7'd1;
               end
               if (mt > 7'd59) begin
                  rolled_in.hour = 1'b1;
                  minute_in = 6'(mt - 7'd60);
                  ht = {1'b0, hour_ff} + 6'd1;
                  if (ht > 6'd23) begin
                     rolled_in.day = 1'b1;
                     hour_in  = 5'd0;
                     days_in  = 2'd1;
                     fwd_in   = 1'b1;
                     state_in = ST_LEAP_MUL;
                  end else begin
                     hour_in = ht[4:0];
                  end
               end else begin
                  minute_in = mt[5:0];
               end
            end else begin
               second_in = s[5:0];
            end
         end

         ST_MIN_DIV: begin
            if (mins_ff >= 11'd60) begin
               mins_in = mins_ff - 11'd60;
               h_in    = h_ff + 6'd1;
            end else begin
               if (h_ff >= 6'd24) begin
                  h_in    = h_ff - 6'd24;
                  days_in = 2'd1;
               end else begin
                  days_in = 2'd0;
               end
               state_in = ST_MIN_APPLY;
            end
         end

         ST_MIN_APPLY: begin
            m  = mins_ff[5:0];
            hh = h_ff[4:0];
            dd = days_ff;
            if (kind_ff == KIND_ADD_MIN) begin
               fwd_in = 1'b1;
               mt = {1'b0, minute_ff} + {1'b0, m};
               if (mt > 7'd59) begin
                  minute_in = (mt >= 7'd120) ? 6'(mt - 7'd120) : 6'(mt - 7'd60);
                  hh = hh + 5'd1;
               end else begin
                  minute_in = mt[5:0];
               end
               ht = {1'b0, hour_ff} + {1'b0, hh};
               if (ht > 6'd23) begin
                  hour_in = (ht >= 6'd48) ? 5'(ht - 6'd48) : 5'(ht - 6'd24);
                  dd = dd + 2'd1;
               end else begin
                  hour_in = ht[4:0];
               end
            end else begin
               fwd_in = 1'b0;
               if (minute_ff >= m) begin
                  minute_in = minute_ff - m;
               end else begin
                  minute_in = minute_ff + 6'd60 - m;
                  hh = hh + 5'd1;
               end
               if (hour_ff >= hh) begin
                  hour_in = hour_ff - hh;
               end else begin
                  hour_in = hour_ff + 5'd24 - hh;
                  dd = dd + 2'd1;
               end
            end
            days_in  = dd;
            state_in = (dd != 2'd0) ? ST_LEAP_MUL : ST_WD_MUL1;
         end

         ST_LEAP_MUL: state_in = ST_LEAP_FIX;

         ST_LEAP_FIX: begin
            leap_in  = leap_calc;
            state_in = ST_STEP;
         end

         ST_STEP: begin
            if (fwd_ff) begin
               mlen = month_len(month_ff, leap_ff);
               d    = {1'b0, day_ff} + 6'd1;
               if (d > {1'b0, mlen}) begin
                  day_in = 5'd1;
                  mn     = {1'b0, month_ff} + 5'd1;
                  if (is_tick) rolled_in.month = 1'b1;
                  if (mn > 5'd12) begin
                     month_in = 4'd1;
                     year_in  = year_ff + 14'd1;
                     if (is_tick) rolled_in.year = 1'b1;
                  end else begin
                     month_in = mn[3:0];
                  end
               end else begin
                  day_in = d[4:0];
               end
            end else begin
               if (day_ff > 5'd1) begin
                  day_in = day_ff - 5'd1;
               end else begin
                  case (month_ff)
                     4'd1: begin
                        day_in   = 5'd31;
                        month_in = 4'd12;
                        year_in  = year_m1;
                     end
                     4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd11: begin
                        day_in   = 5'd31;
                        month_in = month_ff - 4'd1;
                     end
                     4'd5, 4'd7, 4'd10, 4'd12: begin
                        day_in   = 5'd30;
                        month_in = month_ff - 4'd1;
                     end
                     default: begin
                        day_in   = 5'd28 + {4'd0, leap_ff};
                        month_in = month_ff - 4'd1;
                     end
                  endcase
               end
            end
            days_in = days_ff - 2'd1;
            if (days_ff != 2'd1) begin
               state_in = ST_LEAP_MUL;
            end else if (is_tick && (wd_ff != 3'd7)) begin
               wd_in    = (wd_ff >= 3'd6) ? 3'd0 : wd_ff + 3'd1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_WD_MUL1;
            end
         end

         ST_WD_MUL1: begin
            if (year_ff < START_Y) begin
               wd_in    = 3'd7;
               state_in = ST_DONE;
            end else begin
               state_in = ST_WD_MUL2;
            end
         end

         ST_WD_MUL2: begin
            q1_in    = prod_ff[26:19];
            state_in = ST_WD_LEAP;
         end

         ST_WD_LEAP: begin
            leap_in  = leap_calc;
            state_in = ST_WD_SUM;
         end

         ST_WD_SUM: begin
            // 365 is 1 mod 7, so whole years count one each
            sum = {2'd0, year_ff - START_Y} + {4'd0, year_m1[13:2]}
                - {8'd0, q1_ff} + {10'd0, q1_ff[7:2]} - LEAPS_BEFORE
                + {7'd0, month_offset(month_ff)} + {11'd0, day_ff} + WD_BASE;
            if ((month_ff >= 4'd3) && (month_ff <= 4'd12) && leap_ff) begin
               sum = sum + 16'd1;
            end
            n_in     = sum[14:0];
            state_in = ST_WD_MUL7;
         end

         ST_WD_MUL7: state_in = ST_WD_MOD;

         ST_WD_MOD: begin
            q7  = prod_ff[28:16];
            r7  = {1'b0, n_ff} - ({q7, 3'd0} - {3'd0, q7});
            r7n = r7[3:0];
            wd_in    = (r7n >= 4'd7) ? 3'(r7n - 4'd7) : r7n[2:0];
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         year_ff      <= START_Y;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         hour_ff      <= 5'd0;
         minute_ff    <= 6'd0;
         second_ff    <= 6'd0;
         wd_ff        <= START_WD;
         rem_ff       <= 10'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         wd_ff        <= wd_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      ms_ff     <= ms_in;
      mins_ff   <= mins_in;
      h_ff      <= h_in;
      days_ff   <= days_in;
      fwd_ff    <= fwd_in;
      leap_ff   <= leap_in;
      secs_ff   <= secs_in;
      part_ff   <= part_in;
      q1_ff     <= q1_in;
      n_ff      <= n_in;
      rolled_ff <= rolled_in;
      prod_ff   <= prod_in;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_year          <= year_ff;
         rsp_month         <= month_ff;
         rsp_day           <= day_ff;
         rsp_hour          <= hour_ff;
         rsp_minute        <= minute_ff;
         rsp_second        <= second_ff;
         rsp_weekday       <= wd_ff;
         rsp_minute_rolled <= rolled_ff.minute;
         rsp_hour_rolled   <= rolled_ff.hour;
         rsp_day_rolled    <= rolled_ff.day;
         rsp_month_rolled  <= rolled_ff.month;
         rsp_year_rolled   <= rolled_ff.year;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/cwa_checker.sv
// Port-level checker for the calendar clock core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_clock_with_adjust_core_macros.svh"

module cwa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_minute_rolled,
   input wire logic rsp_hour_rolled,
   input wire logic rsp_day_rolled,
   input wire logic rsp_month_rolled,
   input wire logic rsp_year_rolled
);

   // a waiting result word is not dropped
   `CWA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result word dropped")

   // the core is busy right after taking a word
   `CWA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy after accept")

   // carries come as a chain: a roll implies every smaller roll
   `CWA_ASSERT_IMP(a_roll_chain, rsp_valid && (rsp_hour_rolled || rsp_day_rolled || rsp_month_rolled || rsp_year_rolled), rsp_minute_rolled && (rsp_hour_rolled || !rsp_day_rolled) && (rsp_day_rolled || !rsp_month_rolled) && (rsp_month_rolled || !rsp_year_rolled), "broken roll chain")

   `CWA_ASSERT_RST(a_reset_quiet, !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind calendar_clock_with_adjust_core cwa_checker u_cwa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_minute_rolled (rsp_minute_rolled),
   .rsp_hour_rolled   (rsp_hour_rolled),
   .rsp_day_rolled    (rsp_day_rolled),
   .rsp_month_rolled  (rsp_month_rolled),
   .rsp_year_rolled   (rsp_year_rolled)
);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the calendar clock core
`timescale 1ns / 1ps

module testbench;
   import cwa_pkg::*;

   localparam int START_YEAR = 1900;
   localparam int START_WEEKDAY = 1;
   localparam int N_RANDOM = 1880;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] elapsed_ms;
      logic [10:0] minutes;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } clock_cmd_t;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic        r_min, r_hour, r_day, r_month, r_year;
   } clock_view_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_kind = '0;
   logic [15:0] req_elapsed_ms = '0;
   logic [10:0] req_minutes = '0;
   logic [13:0] req_load_year = '0;
   logic [3:0] req_load_month = '0;
   logic [4:0] req_load_day = '0;
   logic [4:0] req_load_hour = '0;
   logic [5:0] req_load_minute = '0;
   logic [5:0] req_load_second = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [13:0] rsp_year;
   logic [3:0] rsp_month;
   logic [4:0] rsp_day, rsp_hour;
   logic [5:0] rsp_minute, rsp_second;
   logic [2:0] rsp_weekday;
   logic rsp_minute_rolled, rsp_hour_rolled, rsp_day_rolled, rsp_month_rolled;
   logic rsp_year_rolled;

   calendar_clock_with_adjust_core #(.START_YEAR(START_YEAR),
      .START_WEEKDAY(START_WEEKDAY)) i_dut (.*);

   always #1 clock = ~clock;

   clock_cmd_t pending_cmds[$];
   clock_view_t expected_views[$];
   int unsigned errors = 0;
   int unsigned n_sent = 0, n_checked = 0;
   longint cycles = 0;
   bit stim_done = 0;
   bit drain_req = 0;    // sender waits for every result
   bit hold_req = 0;     // receiver long hold-off
   int unsigned tick_count = 0, roll_count = 0, load_count = 0;

   // predictor state
   int unsigned c_year, c_month, c_day, c_hour, c_minute, c_second, c_wday, c_ms;

   function automatic int unsigned leap_of(int unsigned y);
      return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
   endfunction

   function automatic int unsigned days_in(int unsigned m, int unsigned y);
      if (m == 1 || m == 3 || m == 5 || m == 7 || m == 8 || m == 10 || m == 12) return 31;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 28 + leap_of(y);
   endfunction

   function automatic int unsigned leaps_upto(int unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic int unsigned weekday_from_date();
      int unsigned days;
      int unsigned offs[16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334,
                               0, 0, 0};
      if (c_year < START_YEAR) return 7;
      days = 365 * (c_year - START_YEAR) + leaps_upto(c_year - 1)
           - leaps_upto(START_YEAR - 1);
      days += offs[c_month & 15];
      if (c_month >= 3 && c_month <= 12) days += leap_of(c_year);
      days += c_day + 6;
      return (START_WEEKDAY + days % 7) % 7;
   endfunction

   function automatic int unsigned step_date_fwd();
      int unsigned flags, d;
      flags = 0;
      d = c_day + 1;
      if (d > days_in(c_month, c_year)) begin
         d = 1;
         flags |= 1;
         c_month++;
         if (c_month > 12) begin
            c_month = 1;
            c_year = (c_year + 1) & 16'h3fff;
            flags |= 2;
         end
      end
      c_day = d & 31;
      return flags;
   endfunction

   function automatic void step_date_back();
      int unsigned m;
      m = c_month;
      if (c_day > 1) begin
         c_day--;
      end else if (m == 1 || m == 2 || m == 4 || m == 6 || m == 8 || m == 9 || m == 11) begin
         c_day = 31;
         if (m == 1) begin
            c_month = 12;
            c_year = (c_year - 1) & 16'h3fff;
         end else begin
            c_month = m - 1;
         end
      end else if (m == 5 || m == 7 || m == 10 || m == 12) begin
         c_day = 30;
         c_month = m - 1;
      end else begin
         c_day = 28 + leap_of(c_year);
         c_month = (m - 1) & 15;
      end
   endfunction

   function automatic clock_view_t advance_clock(clock_cmd_t c);
      clock_view_t v;
      int unsigned secs, m, h, days, f;
      v = '0;
      if (c.kind == KIND_TICK) begin
         secs = c.elapsed_ms / 1000;
         c_ms += c.elapsed_ms % 1000;
         if (c_ms >= 1000) begin
            c_ms -= 1000;
            secs++;
         end
         c_second += secs;
         if (c_second > 59) begin
            c_minute += c_second / 60;
            c_second %= 60;
            v.r_min = 1'b1;
            if (c_minute > 59) begin
               c_hour += c_minute / 60;
               c_minute %= 60;
               v.r_hour = 1'b1;
               if (c_hour > 23) begin
                  c_hour = 0;
                  v.r_day = 1'b1;
                  f = step_date_fwd();
                  v.r_month = f[0];
                  v.r_year = f[1];
                  if (c_wday >= 7) c_wday = weekday_from_date();
                  else c_wday = (c_wday + 1) % 7;
               end
            end
         end
         c_hour &= 31;
      end else if (c.kind == KIND_ADD_MIN || c.kind == KIND_SUB_MIN) begin
         m = c.minutes % 60;
         h = c.minutes / 60;
         days = h / 24;
         h %= 24;
         if (c.kind == KIND_ADD_MIN) begin
            c_minute += m;
            if (c_minute > 59) begin
               c_minute %= 60;
               h++;
            end
            c_hour += h;
            if (c_hour > 23) begin
               c_hour %= 24;
               days++;
            end
            for (int i = 0; i < days; i++) void'(step_date_fwd());
         end else begin
            if (c_minute >= m) c_minute -= m;
            else begin
               c_minute = c_minute + 60 - m;
               h++;
            end
            if (c_hour >= h) c_hour -= h;
            else begin
               c_hour = c_hour + 24 - h;
               days++;
            end
            for (int i = 0; i < days; i++) step_date_back();
         end
         c_wday = weekday_from_date();
      end else if (c.kind == KIND_DAY_FWD) begin
         void'(step_date_fwd());
         c_wday = weekday_from_date();
      end else if (c.kind == KIND_DAY_BACK) begin
         step_date_back();
         c_wday = weekday_from_date();
      end else if (c.kind == KIND_LOAD) begin
         c_year = c.year;
         c_month = c.month;
         c_day = c.day;
         c_hour = c.hour;
         c_minute = c.minute;
         c_second = c.second;
         c_ms = 0;
         c_wday = weekday_from_date();
      end
      c_minute &= 63;
      c_second &= 63;
      v.year = 14'(c_year);
      v.month = 4'(c_month);
      v.day = 5'(c_day);
      v.hour = 5'(c_hour);
      v.minute = 6'(c_minute);
      v.second = 6'(c_second);
      v.weekday = 3'(c_wday);
      return v;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("ERROR word %0d: %s got %0d expected %0d", n_checked, what, got, want);
      errors++;
   endtask

   // stimulus builders
   function automatic clock_cmd_t tick_word(int unsigned ms);
      clock_cmd_t c;
      c = '0;
      c.kind = KIND_TICK;
      c.elapsed_ms = 16'(ms);
      c.minutes = 11'($urandom);
      c.year = 14'($urandom);
      return c;
   endfunction

   function automatic clock_cmd_t load_word(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi,
                                            int unsigned s);
      clock_cmd_t c;
      c = '0;
      c.kind = KIND_LOAD;
      c.elapsed_ms = 16'($urandom);
      c.year = 14'(y);
      c.month = 4'(mo);
      c.day = 5'(d);
      c.hour = 5'(h);
      c.minute = 6'(mi);
      c.second = 6'(s);
      return c;
   endfunction

   function automatic clock_cmd_t adjust_word(logic [2:0] k, int unsigned mins);
      clock_cmd_t c;
      c = '0;
      c.kind = k;
      c.minutes = 11'(mins);
      c.elapsed_ms = 16'($urandom);
      return c;
   endfunction

   function automatic clock_cmd_t random_word();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return tick_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                     : $urandom_range(0, 3000));
      if (sel < 60) return adjust_word(KIND_ADD_MIN, ($urandom_range(0, 7) == 0) ?
                                       $urandom_range(0, 2047) : $urandom_range(0, 1439));
      if (sel < 70) return adjust_word(KIND_SUB_MIN, ($urandom_range(0, 7) == 0) ?
                                       $urandom_range(0, 2047) : $urandom_range(0, 1439));
      if (sel < 77) return adjust_word(KIND_DAY_FWD, $urandom);
      if (sel < 84) return adjust_word(KIND_DAY_BACK, $urandom);
      if (sel < 86) return adjust_word(logic'(1) ? 3'(6 + $urandom_range(0, 1)) : '0,
                                       $urandom);
      if (sel < 96) begin
         // near a month, year or day boundary so the carries get exercised
         return load_word($urandom_range(0, 3) == 0 ? $urandom_range(1800, 2100)
                          : $urandom_range(1900, 9999),
                          $urandom_range(1, 12), $urandom_range(26, 31) <= 28 ?
                          $urandom_range(1, 28) : $urandom_range(28, 31),
                          $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                          $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                          $urandom_range(0, 59));
      end
      // raw fields, out-of-range values included
      return load_word($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
   endfunction

   initial begin
      clock_cmd_t c;
      // directed part
      pending_cmds.push_back(tick_word(0));
      pending_cmds.push_back(tick_word(999));
      pending_cmds.push_back(tick_word(1));
      pending_cmds.push_back(tick_word(65535));
      pending_cmds.push_back(load_word(1999, 12, 31, 23, 59, 58));
      pending_cmds.push_back(tick_word(2500));
      pending_cmds.push_back(load_word(2000, 2, 28, 23, 59, 59));
      pending_cmds.push_back(tick_word(1000));
      pending_cmds.push_back(load_word(1900, 2, 28, 23, 59, 59));
      pending_cmds.push_back(tick_word(1000));
      pending_cmds.push_back(adjust_word(KIND_ADD_MIN, 1439));
      pending_cmds.push_back(adjust_word(KIND_SUB_MIN, 1439));
      pending_cmds.push_back(adjust_word(KIND_ADD_MIN, 2047));
      pending_cmds.push_back(adjust_word(KIND_SUB_MIN, 2047));
      pending_cmds.push_back(load_word(1900, 1, 1, 0, 0, 0));
      pending_cmds.push_back(adjust_word(KIND_DAY_BACK, 0));
      pending_cmds.push_back(adjust_word(KIND_DAY_FWD, 0));
      pending_cmds.push_back(load_word(16383, 12, 31, 31, 63, 63));
      pending_cmds.push_back(tick_word(65535));
      pending_cmds.push_back(load_word(0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(adjust_word(KIND_DAY_BACK, 0));
      pending_cmds.push_back(load_word(5000, 15, 31, 23, 59, 59));
      pending_cmds.push_back(adjust_word(KIND_DAY_FWD, 0));
      pending_cmds.push_back(adjust_word(3'd6, 0));
      pending_cmds.push_back(adjust_word(3'd7, 0));
      for (int i = 0; i < N_RANDOM; i++) begin
         c = random_word();
         pending_cmds.push_back(c);
         if (i == 300) begin
            // wait here while a drain by the sender is in progress
            wait (pending_cmds.size() <= N_RANDOM - 300 && drain_req == 0);
         end
      end
      stim_done = 1;
   end

   // driver
   int unsigned send_gap = 0;
   clock_cmd_t c_next;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_views.push_back(advance_clock(pending_cmds.pop_front()));
            n_sent <= n_sent + 1;
            if (n_sent == 700) drain_req <= 1;
         end
         if (drain_req && expected_views.size() == 0 && !(req_valid && !req_stall))
            drain_req <= 0;
         if (req_valid && !req_stall || !req_valid) begin
            // the accepted word is already popped, so the head is the next one
            if (send_gap > 0 || drain_req || pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               c_next = pending_cmds[0];
               req_valid <= 1'b1;
               req_kind <= c_next.kind;
               req_elapsed_ms <= c_next.elapsed_ms;
               req_minutes <= c_next.minutes;
               req_load_year <= c_next.year;
               req_load_month <= c_next.month;
               req_load_day <= c_next.day;
               req_load_hour <= c_next.hour;
               req_load_minute <= c_next.minute;
               req_load_second <= c_next.second;
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
         end
      end
   end

   // receiver hold-off and monitor
   int unsigned recv_gap = 0;
   int unsigned hold_cycles = 0;
   always @(posedge clock) begin
      clock_view_t e;
      if (!reset) begin
         if (n_sent == 400 && hold_cycles == 0 && !hold_req) begin
            hold_req <= 1;
            hold_cycles <= 3000;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
         end
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected word, queue depth", 0, 1);
            end else begin
               e = expected_views.pop_front();
               if (rsp_year != e.year) report_mismatch("year", rsp_year, e.year);
               if (rsp_month != e.month) report_mismatch("month", rsp_month, e.month);
               if (rsp_day != e.day) report_mismatch("day", rsp_day, e.day);
               if (rsp_hour != e.hour) report_mismatch("hour", rsp_hour, e.hour);
               if (rsp_minute != e.minute) report_mismatch("minute", rsp_minute, e.minute);
               if (rsp_second != e.second) report_mismatch("second", rsp_second, e.second);
               if (rsp_weekday != e.weekday)
                  report_mismatch("weekday", rsp_weekday, e.weekday);
               if (rsp_minute_rolled != e.r_min)
                  report_mismatch("minute_rolled", rsp_minute_rolled, e.r_min);
               if (rsp_hour_rolled != e.r_hour)
                  report_mismatch("hour_rolled", rsp_hour_rolled, e.r_hour);
               if (rsp_day_rolled != e.r_day)
                  report_mismatch("day_rolled", rsp_day_rolled, e.r_day);
               if (rsp_month_rolled != e.r_month)
                  report_mismatch("month_rolled", rsp_month_rolled, e.r_month);
               if (rsp_year_rolled != e.r_year)
                  report_mismatch("year_rolled", rsp_year_rolled, e.r_year);
               if (e.r_day) roll_count++;
            end
         end
         if (hold_cycles > 1) begin
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall || rsp_stall) begin
            if (recv_gap > 0) begin
               rsp_stall <= 1'b1;
               recv_gap <= recv_gap - 1;
            end else begin
               rsp_stall <= 1'b0;
               recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      c_year = START_YEAR;
      c_month = 1;
      c_day = 1;
      c_hour = 0;
      c_minute = 0;
      c_second = 0;
      c_wday = START_WEEKDAY;
      c_ms = 0;
      while (!(stim_done && pending_cmds.size() == 0 && !req_valid &&
               expected_views.size() == 0) && cycles < CYCLE_LIMIT)
         @(posedge clock);
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout with %0d words outstanding", expected_views.size());
         $display("Verification failed");
         $finish;
      end else begin
         repeat (80) @(posedge clock);
         $display("Sent %0d words, checked %0d results, %0d day rolls seen, %0d errors",
                  n_sent, n_checked, roll_count, errors);
         $display("Covered ticks, minute adjusts, day steps, loads and unused kinds");
         if (errors == 0 && expected_views.size() == 0)
            $display("Verification passed");
         else
            $display("Verification failed");
         $finish;
      end
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/cwa_pkg.sv
rtl/core/calendar_clock_with_adjust_core.sv
rtl/core/cwa_checker.sv
tb/sv/testbench.sv
